@@ rtl/gpfc_pkg.sv @@
`timescale 1ns / 1ps

package gpfc_pkg;

  // Centering gains on the finger midpoint, N/m and N s/m
  localparam logic signed [9:0] CENTER_KP = 10'sd400;
  localparam logic signed [9:0] CENTER_KV = 10'sd40;

  localparam logic [1:0] MODE_MOVE  = 2'd0;
  localparam logic [1:0] MODE_GRASP = 2'd1;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DESIRED_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DESIRED_SPEED  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DESIRED_FORCE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GRIP_MODE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STIFFNESS_GAIN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING_GAIN   = 3'd6;

  localparam int CONSTR_W = 34;
  localparam int P_TERM_W = 34;
  localparam int D_TERM_W = 42;
  localparam int SUM_W    = 44;

  typedef struct packed {
    logic signed [15:0] finger_one_pos;
    logic signed [15:0] finger_two_pos;
    logic signed [23:0] finger_one_vel;
    logic signed [23:0] finger_two_vel;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] torque_one;
    logic signed [31:0] torque_two;
    logic signed [15:0] half_open;
    logic        [3:0]  clamp_flags;
    logic               mode_unknown;
  } result_t;

  typedef struct packed {
    logic signed [15:0] set_width;
    logic signed [23:0] set_speed;
    logic signed [31:0] set_force;
    logic        [1:0]  grip_mode;
    logic        [14:0] max_width;
    logic        [15:0] stiffness_gain;
    logic        [15:0] damping_gain;
  } cfg_t;

  // Products and clamped terms handed from the front stage to the summing stage
  typedef struct packed {
    logic signed [CONSTR_W-1:0] constraint_force;
    logic signed [P_TERM_W-1:0] p_term;
    logic signed [D_TERM_W-1:0] d_term;
    logic signed [31:0]         grasp_force;
    logic        [1:0]          grip_mode;
    logic signed [15:0]         width;
    logic        [3:0]          clamp_flags;
  } terms_t;

endpackage

@@ rtl/gpfc_regs.sv @@
`timescale 1ns / 1ps

module gpfc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gpfc_pkg::cfg_t      cfg
);

  logic                              wr_en;
  logic [gpfc_pkg::REG_IDX_W-1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_width      <= 16'sd2621;
      cfg.set_speed      <= '0;
      cfg.set_force      <= '0;
      cfg.grip_mode      <= gpfc_pkg::MODE_MOVE;
      cfg.max_width      <= 15'd5243;
      cfg.stiffness_gain <= 16'd400;
      cfg.damping_gain   <= 16'd40;
    end else if (wr_en) begin
      unique case (idx)
        gpfc_pkg::REG_DESIRED_WIDTH:  cfg.set_width      <= pwdata[15:0];
        gpfc_pkg::REG_DESIRED_SPEED:  cfg.set_speed      <= pwdata[23:0];
        gpfc_pkg::REG_DESIRED_FORCE:  cfg.set_force      <= pwdata;
        gpfc_pkg::REG_GRIP_MODE:      cfg.grip_mode      <= pwdata[1:0];
        gpfc_pkg::REG_MAX_WIDTH:      cfg.max_width      <= pwdata[14:0];
        gpfc_pkg::REG_STIFFNESS_GAIN: cfg.stiffness_gain <= pwdata[15:0];
        gpfc_pkg::REG_DAMPING_GAIN:   cfg.damping_gain   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gpfc_pkg::REG_DESIRED_WIDTH:  prdata = {16'b0, cfg.set_width};
      gpfc_pkg::REG_DESIRED_SPEED:  prdata = {8'b0, cfg.set_speed};
      gpfc_pkg::REG_DESIRED_FORCE:  prdata = cfg.set_force;
      gpfc_pkg::REG_GRIP_MODE:      prdata = {30'b0, cfg.grip_mode};
      gpfc_pkg::REG_MAX_WIDTH:      prdata = {17'b0, cfg.max_width};
      gpfc_pkg::REG_STIFFNESS_GAIN: prdata = {16'b0, cfg.stiffness_gain};
      gpfc_pkg::REG_DAMPING_GAIN:   prdata = {16'b0, cfg.damping_gain};
      default:                      prdata = '0;
    endcase
  end

endmodule

@@ rtl/gpfc_front.sv @@
`timescale 1ns / 1ps

module gpfc_front (
  input  logic                clk,
  input  logic                rst,
  input  gpfc_pkg::cfg_t      cfg,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  gpfc_pkg::sample_t   sample,
  output logic                terms_valid,
  input  logic                terms_ready,
  output gpfc_pkg::terms_t    terms
);

  gpfc_pkg::sample_t  smp;
  logic               smp_valid;
  logic               terms_en;
  gpfc_pkg::terms_t   terms_next;

  logic signed [16:0] pos_sum, pos_dif;
  logic signed [24:0] vel_sum, vel_dif;
  logic signed [15:0] centre, width;
  logic signed [23:0] centre_vel, speed;
  logic               dw_over, dw_under, ds_under, df_under;
  logic signed [15:0] dw;
  logic signed [23:0] ds;
  logic signed [31:0] df;
  logic signed [16:0] width_err;
  logic signed [24:0] speed_err;

  assign terms_en     = !terms_valid || terms_ready;
  assign sample_ready = !smp_valid || terms_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample_ready) begin
      smp_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      smp <= sample;
    end
  end

  always_comb begin
    pos_sum = 17'(smp.finger_one_pos) + 17'(smp.finger_two_pos);
    pos_dif = 17'(smp.finger_one_pos) - 17'(smp.finger_two_pos);
    vel_sum = 25'(smp.finger_one_vel) + 25'(smp.finger_two_vel);
    vel_dif = 25'(smp.finger_one_vel) - 25'(smp.finger_two_vel);
    // arithmetic halving: drop the low bit
    centre     = pos_sum[16:1];
    width      = pos_dif[16:1];
    centre_vel = vel_sum[24:1];
    speed      = vel_dif[24:1];

    // max_width is never negative, so over and under are exclusive
    dw_over  = cfg.set_width > $signed({1'b0, cfg.max_width});
    dw_under = cfg.set_width[15];
    ds_under = cfg.set_speed[23];
    df_under = cfg.set_force[31];
    dw = dw_over ? $signed({1'b0, cfg.max_width}) : (dw_under ? '0 : cfg.set_width);
    ds = ds_under ? '0 : cfg.set_speed;
    df = df_under ? '0 : cfg.set_force;

    width_err = 17'(width) - 17'(dw);
    speed_err = 25'(speed) - 25'(ds);

    terms_next.constraint_force =
        -(34'(centre) * 34'(gpfc_pkg::CENTER_KP))
        - (34'(centre_vel) * 34'(gpfc_pkg::CENTER_KV));
    terms_next.p_term =
        34'(width_err) * 34'($signed({1'b0, cfg.stiffness_gain}));
    terms_next.d_term =
        42'(speed_err) * 42'($signed({1'b0, cfg.damping_gain}));
    terms_next.grasp_force = df;
    terms_next.grip_mode   = cfg.grip_mode;
    terms_next.width       = width;
    terms_next.clamp_flags = {df_under, ds_under, dw_under, dw_over};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (terms_en) begin
      terms_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (terms_en && smp_valid) begin
      terms <= terms_next;
    end
  end

endmodule

@@ rtl/gpfc_back.sv @@
`timescale 1ns / 1ps

module gpfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                terms_valid,
  output logic                terms_ready,
  input  gpfc_pkg::terms_t    terms,
  output logic                result_valid,
  input  logic                result_ready,
  output gpfc_pkg::result_t   result
);

  localparam logic signed [gpfc_pkg::SUM_W-1:0] SAT_MAX = 44'sd2147483647;
  localparam logic signed [gpfc_pkg::SUM_W-1:0] SAT_MIN = -44'sd2147483648;

  logic signed [gpfc_pkg::SUM_W-1:0] behave, sum_one, sum_two, constr;
  logic                              unknown;
  gpfc_pkg::result_t                 result_next;

  function automatic logic signed [31:0] sat32(input logic signed [gpfc_pkg::SUM_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  assign terms_ready = !result_valid || result_ready;

  always_comb begin
    unknown = 1'b0;
    case (terms.grip_mode)
      gpfc_pkg::MODE_MOVE:  behave = -44'(terms.p_term) - 44'(terms.d_term);
      gpfc_pkg::MODE_GRASP: behave = -44'(terms.grasp_force);
      default: begin
        behave  = '0;
        unknown = 1'b1;
      end
    endcase
    constr  = 44'(terms.constraint_force);
    sum_one = constr + behave;
    sum_two = constr - behave;

    result_next.torque_one   = sat32(sum_one);
    result_next.torque_two   = sat32(sum_two);
    result_next.half_open    = terms.width;
    result_next.clamp_flags  = terms.clamp_flags;
    result_next.mode_unknown = unknown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (terms_ready) begin
      result_valid <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (terms_ready && terms_valid) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/gripper_pd_force_control.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                        Payload
// sample    sample_valid / sample_ready      sample   (finger positions, velocities)
// result    result_valid / result_ready      result   (torques, width, flags)
// config    APB psel/penable/pwrite, pready  paddr, pwdata, prdata (7 regs at 4*i)
//
// One sample per cycle while result is not stalled; result_valid rises once the sample has passed
// the input register, product register and result register.
// The two gain multipliers in the front stage set the cycle time.
// Synchronous active-high rst empties the pipeline and loads register defaults.
// A stall on result holds each stage; sample_ready drops only when all are full.

module gripper_pd_force_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  gpfc_pkg::sample_t   sample,
  output logic                result_valid,
  input  logic                result_ready,
  output gpfc_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  gpfc_pkg::cfg_t    cfg;
  gpfc_pkg::terms_t  terms;
  logic              terms_valid;
  logic              terms_ready;

  gpfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .terms_valid  (terms_valid),
    .terms_ready  (terms_ready),
    .terms        (terms)
  );

  gpfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .terms_valid  (terms_valid),
    .terms_ready  (terms_ready),
    .terms        (terms),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int PIPE_LATENCY   = 3;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 50;

  // grip_mode codes the block does not recognize
  localparam logic [1:0] MODE_UNKNOWN    = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN_HI = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  gpfc_pkg::sample_t     sample_in = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  gpfc_pkg::result_t     result_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [4:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  gpfc_pkg::cfg_t    cfg_shadow;
  gpfc_pkg::result_t torque_q[$];
  gpfc_pkg::result_t want;
  int                fail_count = 0;
  int                idle_cycles = 0;
  bit                idle_on = 1'b1;
  int                hold_reqs = 0;

  gripper_pd_force_control uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] sat_torque(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic gpfc_pkg::result_t predict_torques(gpfc_pkg::sample_t s,
                                                        gpfc_pkg::cfg_t c);
    longint p1, p2, v1, v2;
    longint centre, centre_vel, width, speed;
    longint dw, ds, df, maxw, kp, kv;
    longint constr, behave;
    gpfc_pkg::result_t r;
    p1 = s.finger_one_pos;
    p2 = s.finger_two_pos;
    v1 = s.finger_one_vel;
    v2 = s.finger_two_vel;
    // halving rounds toward minus infinity
    centre     = (p1 + p2) >>> 1;
    centre_vel = (v1 + v2) >>> 1;
    width      = (p1 - p2) >>> 1;
    speed      = (v1 - v2) >>> 1;
    dw   = c.set_width;
    ds   = c.set_speed;
    df   = c.set_force;
    maxw = c.max_width;
    kp   = c.stiffness_gain;
    kv   = c.damping_gain;
    r.clamp_flags = '0;
    if (dw > maxw) begin
      dw = maxw;
      r.clamp_flags[0] = 1'b1;
    end
    if (dw < 0) begin
      dw = 0;
      r.clamp_flags[1] = 1'b1;
    end
    if (ds < 0) begin
      ds = 0;
      r.clamp_flags[2] = 1'b1;
    end
    if (df < 0) begin
      df = 0;
      r.clamp_flags[3] = 1'b1;
    end
    constr = -longint'(gpfc_pkg::CENTER_KP) * centre
             - longint'(gpfc_pkg::CENTER_KV) * centre_vel;
    behave = 0;
    r.mode_unknown = 1'b0;
    case (c.grip_mode)
      gpfc_pkg::MODE_MOVE:  behave = -kp * (width - dw) - kv * (speed - ds);
      gpfc_pkg::MODE_GRASP: behave = -df;
      default:              r.mode_unknown = 1'b1;
    endcase
    r.torque_one = sat_torque(constr + behave);
    r.torque_two = sat_torque(constr - behave);
    r.half_open  = width[15:0];
    return r;
  endfunction

  function automatic gpfc_pkg::sample_t mk_sample(int p1, int p2, int v1, int v2);
    gpfc_pkg::sample_t s;
    s.finger_one_pos = 16'(p1);
    s.finger_two_pos = 16'(p2);
    s.finger_one_vel = 24'(v1);
    s.finger_two_vel = 24'(v2);
    return s;
  endfunction

  function automatic gpfc_pkg::cfg_t make_config(int dw, int ds, int df, logic [1:0] mode,
                                                 int maxw, int kp, int kv);
    gpfc_pkg::cfg_t c;
    c.set_width      = 16'(dw);
    c.set_speed      = 24'(ds);
    c.set_force      = df;
    c.grip_mode      = mode;
    c.max_width      = 15'(maxw);
    c.stiffness_gain = 16'(kp);
    c.damping_gain   = 16'(kv);
    return c;
  endfunction

  function automatic gpfc_pkg::sample_t rand_sample();
    gpfc_pkg::sample_t s;
    if ($urandom_range(0, 1) == 1) begin
      s.finger_one_pos = 16'($urandom);
      s.finger_two_pos = 16'($urandom);
    end else begin
      s.finger_one_pos = 16'(int'($urandom_range(0, 8000)) - 4000);
      s.finger_two_pos = 16'(int'($urandom_range(0, 8000)) - 4000);
    end
    if ($urandom_range(0, 1) == 1) begin
      s.finger_one_vel = 24'($urandom);
      s.finger_two_vel = 24'($urandom);
    end else begin
      s.finger_one_vel = 24'(int'($urandom_range(0, 4000)) - 2000);
      s.finger_two_vel = 24'(int'($urandom_range(0, 4000)) - 2000);
    end
    return s;
  endfunction

  function automatic gpfc_pkg::cfg_t rand_config();
    gpfc_pkg::cfg_t c;
    int             pick;
    pick = $urandom_range(0, 19);
    if (pick < 12)      c.grip_mode = gpfc_pkg::MODE_MOVE;
    else if (pick < 17) c.grip_mode = gpfc_pkg::MODE_GRASP;
    else if (pick[0])   c.grip_mode = MODE_UNKNOWN;
    else                c.grip_mode = MODE_UNKNOWN_HI;
    c.max_width = 15'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8000));
    if ($urandom_range(0, 2) == 0) c.set_width = 16'($urandom);
    else c.set_width = 16'($urandom_range(0, c.max_width));
    c.set_speed = 24'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3000));
    c.set_force = $urandom;
    c.stiffness_gain = 16'(($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1000));
    c.damping_gain   = 16'(($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 100));
    return c;
  endfunction

  task automatic send_sample(gpfc_pkg::sample_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_in    <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (torque_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Writes every register, with junk above each register's width, plus the
  // unused slot past the register file, which the block has to ignore.
  // The pipe is emptied first so no sample sees a half-written setup.
  task automatic set_config(gpfc_pkg::cfg_t c);
    logic [gpfc_pkg::REG_IDX_W-1:0] idx;
    logic [31:0]                    wdata;
    drain_results();
    for (int i = 0; i < 8; i++) begin
      idx   = gpfc_pkg::REG_IDX_W'(i);
      wdata = $urandom;
      case (idx)
        gpfc_pkg::REG_DESIRED_WIDTH:  wdata[15:0] = c.set_width;
        gpfc_pkg::REG_DESIRED_SPEED:  wdata[23:0] = c.set_speed;
        gpfc_pkg::REG_DESIRED_FORCE:  wdata       = c.set_force;
        gpfc_pkg::REG_GRIP_MODE:      wdata[1:0]  = c.grip_mode;
        gpfc_pkg::REG_MAX_WIDTH:      wdata[14:0] = c.max_width;
        gpfc_pkg::REG_STIFFNESS_GAIN: wdata[15:0] = c.stiffness_gain;
        gpfc_pkg::REG_DAMPING_GAIN:   wdata[15:0] = c.damping_gain;
        default: ;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic test_reset_defaults();
    cfg_shadow = make_config(2621, 0, 0, gpfc_pkg::MODE_MOVE, 5243, 400, 40);
    send_sample(mk_sample(0, 0, 0, 0));
    send_sample(mk_sample(3000, -3000, 500, -500));
    send_sample(mk_sample(-100, 200, -7, 9));
    drain_results();
  endtask

  task automatic test_move_extremes();
    set_config(make_config(32767, 8388607, 32'sh7fff_ffff, gpfc_pkg::MODE_MOVE,
                           32767, 65535, 65535));
    send_sample(mk_sample(0, 0, 0, 0));
    send_sample(mk_sample(32767, -32768, 8388607, -8388608));
    send_sample(mk_sample(-32768, 32767, -8388608, 8388607));
    send_sample(mk_sample(32767, 32767, 8388607, 8388607));
    send_sample(mk_sample(-32768, -32768, -8388608, -8388608));
    // odd sums: halving must floor
    send_sample(mk_sample(1, 0, 1, 0));
    send_sample(mk_sample(-1, 0, -1, 0));
    send_sample(mk_sample(0, 1, 0, 1));
    drain_results();
  endtask

  task automatic test_setpoint_clamps();
    // everything negative, gains zero: width, speed and force clamps at once
    set_config(make_config(-32768, -8388608, 32'sh8000_0000, gpfc_pkg::MODE_MOVE, 0, 0, 0));
    send_sample(mk_sample(32767, -32768, 8388607, -8388608));
    send_sample(mk_sample(1200, 800, -30, 40));
    // width above the limit
    set_config(make_config(6000, 100, 5, gpfc_pkg::MODE_MOVE, 5243, 400, 40));
    send_sample(mk_sample(4000, -4000, 300, -300));
    // positive width against a zero limit
    set_config(make_config(1, 1, 1, gpfc_pkg::MODE_MOVE, 0, 1000, 10));
    send_sample(mk_sample(20, -20, 2, -2));
    drain_results();
  endtask

  task automatic test_grasp_mode();
    set_config(make_config(0, 0, 32'sh7fff_ffff, gpfc_pkg::MODE_GRASP, 5243, 400, 40));
    send_sample(mk_sample(-32768, -32768, -8388608, -8388608));
    send_sample(mk_sample(32767, 32767, 8388607, 8388607));
    set_config(make_config(0, 0, -5, gpfc_pkg::MODE_GRASP, 5243, 400, 40));
    send_sample(mk_sample(100, -100, 10, -10));
    set_config(make_config(2621, 0, 0, gpfc_pkg::MODE_GRASP, 5243, 400, 40));
    send_sample(mk_sample(500, 100, 0, 0));
    drain_results();
  endtask

  task automatic test_unknown_mode();
    set_config(make_config(-10, -10, -10, MODE_UNKNOWN, 5243, 400, 40));
    send_sample(mk_sample(32767, -32768, 8388607, -8388608));
    send_sample(mk_sample(-32768, -32768, -8388608, -8388608));
    set_config(make_config(9000, 50, 77, MODE_UNKNOWN_HI, 5243, 400, 40));
    send_sample(mk_sample(32767, 32767, 8388607, 8388607));
    send_sample(mk_sample(-3, 5, -11, 13));
    drain_results();
  endtask

  // Result side holds off while samples keep coming, so the pipe fills up
  task automatic test_output_stall();
    set_config(rand_config());
    idle_on = 1'b0;
    hold_reqs++;
    repeat (40) send_sample(rand_sample());
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(rand_config());
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_sample(rand_sample());
      drain_results();
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    int holds_done;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (hold_reqs != holds_done) begin
        stall      = HOLD_CYCLES;
        holds_done = hold_reqs;
      end else begin
        stall = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // compare outgoing transfers first, then record the incoming one
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (torque_q.size() == 0) begin
          $error("result transfer with nothing pending");
          fail_count++;
        end else begin
          want = torque_q.pop_front();
          if (result_out.torque_one !== want.torque_one) begin
            $error("torque_one: expected %0d, got %0d", want.torque_one, result_out.torque_one);
            fail_count++;
          end
          if (result_out.torque_two !== want.torque_two) begin
            $error("torque_two: expected %0d, got %0d", want.torque_two, result_out.torque_two);
            fail_count++;
          end
          if (result_out.half_open !== want.half_open) begin
            $error("half_open: expected %0d, got %0d",
                   want.half_open, result_out.half_open);
            fail_count++;
          end
          if (result_out.clamp_flags !== want.clamp_flags) begin
            $error("clamp_flags: expected %b, got %b", want.clamp_flags, result_out.clamp_flags);
            fail_count++;
          end
          if (result_out.mode_unknown !== want.mode_unknown) begin
            $error("mode_unknown: expected %b, got %b",
                   want.mode_unknown, result_out.mode_unknown);
            fail_count++;
          end
        end
      end
      if (sample_valid && sample_ready)
        torque_q.insert(torque_q.size(), predict_torques(sample_in, cfg_shadow));
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_move_extremes();
    test_setpoint_clamps();
    test_grasp_mode();
    test_unknown_mode();
    test_output_stall();
    test_random_traffic();
    if (torque_q.size() != 0)
      $error("%0d results never arrived", torque_q.size());
    if (fail_count == 0 && torque_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gpfc_pkg.sv
rtl/gpfc_regs.sv
rtl/gpfc_front.sv
rtl/gpfc_back.sv
rtl/gripper_pd_force_control.sv
sim/tb.sv
